>>> design/mtnc_pkg.sv
// Package for the markup tag nesting checker: result item type, token kinds,
// character codes, tag and line-word text tables. No dependencies.
`default_nettype none

package mtnc_pkg;

  // Stack of open elements
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned NUM_TAGS      = 14;
  localparam int unsigned LINE_WORD_LEN = 17;

  // Token kinds
  localparam logic [1:0] KIND_OPEN    = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_WORD    = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  // Characters
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [2:0] tag_code;
    logic [7:0] word_length;
    logic       well_formed;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic wr0;  // store first result
    logic wr1;  // store second result too (only with wr0)
  } fifo_push_t;

  // Length of tag idx in characters
  function automatic logic [3:0] tag_len(input logic [3:0] idx);
    logic [3:0] len;
    case (idx)
      4'd0:    len = 4'd10;
      4'd1:    len = 4'd11;
      4'd2:    len = 4'd8;
      4'd3:    len = 4'd9;
      4'd4:    len = 4'd9;
      4'd5:    len = 4'd10;
      4'd6:    len = 4'd7;
      4'd7:    len = 4'd8;
      4'd8:    len = 4'd7;
      4'd9:    len = 4'd8;
      4'd10:   len = 4'd6;
      4'd11:   len = 4'd7;
      4'd12:   len = 4'd11;
      4'd13:   len = 4'd12;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  // Character at position pos of tag idx; zero past its end
  function automatic logic [7:0] tag_char(input logic [3:0] idx, input logic [3:0] pos);
    logic [95:0] txt;
    logic [3:0]  len;
    logic [3:0]  off;
    logic [7:0]  ch;
    case (idx)
      4'd0:    txt = 96'("<document>");
      4'd1:    txt = 96'("</document>");
      4'd2:    txt = 96'("<annexe>");
      4'd3:    txt = 96'("</annexe>");
      4'd4:    txt = 96'("<section>");
      4'd5:    txt = 96'("</section>");
      4'd6:    txt = 96'("<titre>");
      4'd7:    txt = 96'("</titre>");
      4'd8:    txt = 96'("<liste>");
      4'd9:    txt = 96'("</liste>");
      4'd10:   txt = 96'("<item>");
      4'd11:   txt = 96'("</item>");
      4'd12:   txt = 96'("<important>");
      4'd13:   txt = 96'("</important>");
      default: txt = '0;
    endcase
    len = tag_len(idx);
    off = len - pos - 4'd1;
    ch  = (pos < len) ? txt[{off, 3'b000} +: 8] : 8'd0;
    return ch;
  endfunction

  // Character at position pos of the line-break word; zero past its end
  function automatic logic [7:0] line_char(input logic [4:0] pos);
    logic [135:0] txt;
    logic [4:0]   off;
    logic [7:0]   ch;
    // ASCII codes of the line-break word, first character in the top byte
    txt = 136'h72_65_74_6F_75_72_5F_61_5F_6C_61_5F_6C_69_67_6E_65;
    off = 5'(LINE_WORD_LEN) - pos - 5'd1;
    ch  = (pos < 5'(LINE_WORD_LEN)) ? txt[{off, 3'b000} +: 8] : 8'd0;
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> design/mtnc_out_fifo.sv
// Small result queue for the markup tag nesting checker: takes up to two
// result items per cycle, hands out one. Depends on mtnc_pkg.
`default_nettype none

module mtnc_out_fifo (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire mtnc_pkg::fifo_push_t                  push_i,
  input  wire mtnc_pkg::result_t                     data0_i,
  input  wire mtnc_pkg::result_t                     data1_i,
  input  wire logic                                  pop_i,
  output mtnc_pkg::result_t                          head_o,
  output logic                                       valid_o,
  output logic [mtnc_pkg::FIFO_CNT_W-1:0]            count_o
);

  mtnc_pkg::result_t                      entry_q [mtnc_pkg::FIFO_DEPTH];
  logic [mtnc_pkg::FIFO_PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [mtnc_pkg::FIFO_PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [mtnc_pkg::FIFO_CNT_W-1:0]        count_q, count_d;
  logic [mtnc_pkg::FIFO_PTR_W-1:0]        wr_ptr_nxt;
  logic                                   do_pop;

  assign do_pop     = pop_i && (count_q != '0);
  assign wr_ptr_nxt = wr_ptr_q + mtnc_pkg::FIFO_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.wr0 && push_i.wr1) begin
      wr_ptr_d = wr_ptr_q + mtnc_pkg::FIFO_PTR_W'(2);
    end else if (push_i.wr0) begin
      wr_ptr_d = wr_ptr_nxt;
    end
    rd_ptr_d = do_pop ? rd_ptr_q + mtnc_pkg::FIFO_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + mtnc_pkg::FIFO_CNT_W'(push_i.wr0)
                       + mtnc_pkg::FIFO_CNT_W'(push_i.wr1 && push_i.wr0)
                       - mtnc_pkg::FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.wr0) begin
      entry_q[wr_ptr_q] <= data0_i;
    end
    if (push_i.wr0 && push_i.wr1) begin
      entry_q[wr_ptr_nxt] <= data1_i;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

`default_nettype wire

>>> design/markup_tag_nesting_checker.sv
// Top level of the markup tag nesting checker: tokenizer, tag matcher,
// element stack and verdict. Depends on mtnc_pkg and mtnc_out_fifo.
`default_nettype none

// Usage
//   Feed the document one byte per item on the s_axis channel; s_axis_tlast
//   marks the end of the document (its tdata is ignored). Results come out on
//   m_axis: tuser is the token kind (open tag, close tag, word, verdict),
//   tdata carries tag code, word length and the well-formed flag, tlast marks
//   the last result caused by one input item.
//   Results are registered in the result queue and presented from its head.
//   Throughput: one item per cycle, sustained, while the receiver
//   keeps up. An end marker with a pending word gives two results, which
//   drain one per cycle from a four-entry result queue.
//   The stack top is read through a registered memory port from the settled
//   depth; tags are at least six items long, so the read data is always
//   ready when the next tag completes.
//   Stall: tready drops when the result queue holds more than two items, so
//   a stalled receiver never loses results; accepted items are never dropped.
//   Reset: all state returns to "between tokens", empty stack, no error. The
//   stack memory needs no clearing pass; the end marker restores the same
//   state as reset after the verdict.

module markup_tag_nesting_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_input
  // Result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [2:0] tag_code, [10:3] word_length,
                                           // [11] well_formed, [15:12] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] token_kind
  output logic             m_axis_tlast    // last_result
);

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_TAG,
    MODE_WORD
  } lex_mode_e;

  // Tokenizer state
  lex_mode_e                          mode_q, mode_d;
  logic [mtnc_pkg::NUM_TAGS-1:0]      cand_q, cand_d;
  logic [7:0]                         pos_q, pos_d;
  logic                               lw_match_q, lw_match_d;
  logic [mtnc_pkg::DEPTH_W-1:0]       depth_q, depth_d;
  logic                               err_q, err_d;

  // Stack memory; top entry read back through a register
  logic [2:0]                         stack_mem [mtnc_pkg::STACK_DEPTH];
  logic [2:0]                         top_q;
  logic [mtnc_pkg::ADDR_W-1:0]        top_addr;
  logic                               push_en;
  logic [2:0]                         push_code;

  // Result queue hookup
  mtnc_pkg::fifo_push_t               fifo_push;
  mtnc_pkg::result_t                  res0, res1, head;
  logic                               head_valid;
  logic [mtnc_pkg::FIFO_CNT_W-1:0]    fifo_count;

  logic                               in_fire;
  logic [7:0]                         ch;
  logic                               is_sep;
  logic [mtnc_pkg::NUM_TAGS-1:0]      keep;
  logic [mtnc_pkg::NUM_TAGS-1:0]      hit;
  logic                               hit_any;
  logic                               hit_close;
  logic [2:0]                         hit_code;
  logic [7:0]                         pos_inc;
  logic                               word_reported;

  assign s_axis_tready = (fifo_count <= mtnc_pkg::FIFO_CNT_W'(mtnc_pkg::FIFO_DEPTH - 2));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign ch            = s_axis_tdata;
  assign is_sep        = (ch == mtnc_pkg::CHAR_SPACE) || (ch == mtnc_pkg::CHAR_NL);
  assign pos_inc       = (pos_q == 8'hFF) ? pos_q : pos_q + 8'd1;

  // A finished word is reported unless it is the line-break word or an
  // error already froze reporting.
  assign word_reported = !(lw_match_q && (pos_q == 8'(mtnc_pkg::LINE_WORD_LEN))) && !err_q;

  // Parallel compare of the current character against every tag still live
  always_comb begin
    for (int j = 0; j < mtnc_pkg::NUM_TAGS; j++) begin
      keep[j] = cand_q[j]
             && (pos_q < {4'd0, mtnc_pkg::tag_len(4'(j))})
             && (mtnc_pkg::tag_char(4'(j), pos_q[3:0]) == ch);
      hit[j]  = keep[j]
             && ({5'd0, mtnc_pkg::tag_len(4'(j))} == {1'b0, pos_q} + 9'd1);
    end
  end

  // At most one tag can complete: its encoding picks kind and element
  always_comb begin
    hit_close = 1'b0;
    hit_code  = 3'd0;
    for (int j = 0; j < mtnc_pkg::NUM_TAGS; j++) begin
      if (hit[j]) begin
        hit_close = 1'(j % 2);
        hit_code  = 3'(j / 2);
      end
    end
  end
  assign hit_any = |hit;

  // Next state and results for the accepted item
  always_comb begin
    mode_d     = mode_q;
    cand_d     = cand_q;
    pos_d      = pos_q;
    lw_match_d = lw_match_q;
    depth_d    = depth_q;
    err_d      = err_q;
    push_en    = 1'b0;
    push_code  = hit_code;
    fifo_push  = '0;
    res0       = '0;
    res1       = '0;

    if (in_fire) begin
      if (s_axis_tlast) begin
        // Flush a pending word, then the verdict; return to reset state
        if ((mode_q == MODE_WORD) && word_reported) begin
          res0.token_kind  = mtnc_pkg::KIND_WORD;
          res0.word_length = pos_q;
          res1.token_kind  = mtnc_pkg::KIND_VERDICT;
          res1.well_formed = !err_q && (depth_q == '0);
          res1.last_result = 1'b1;
          fifo_push        = '{wr0: 1'b1, wr1: 1'b1};
        end else begin
          res0.token_kind  = mtnc_pkg::KIND_VERDICT;
          res0.well_formed = !err_q && (depth_q == '0);
          res0.last_result = 1'b1;
          fifo_push.wr0    = 1'b1;
        end
        mode_d     = MODE_BETWEEN;
        cand_d     = '0;
        pos_d      = '0;
        lw_match_d = 1'b0;
        depth_d    = '0;
        err_d      = 1'b0;
      end else begin
        case (mode_q)
          MODE_TAG: begin
            if (ch == mtnc_pkg::CHAR_GT) begin
              if (hit_any && !err_q) begin
                res0.token_kind  = hit_close ? mtnc_pkg::KIND_CLOSE : mtnc_pkg::KIND_OPEN;
                res0.tag_code    = hit_code;
                res0.last_result = 1'b1;
                fifo_push.wr0    = 1'b1;
                if (!hit_close) begin
                  // Push; a full stack is an overflow
                  if (depth_q >= mtnc_pkg::DEPTH_W'(mtnc_pkg::STACK_DEPTH)) begin
                    err_d = 1'b1;
                  end else begin
                    push_en = 1'b1;
                    depth_d = depth_q + mtnc_pkg::DEPTH_W'(1);
                  end
                end else begin
                  // Pop; empty stack or wrong element is an error
                  if (depth_q == '0) begin
                    err_d = 1'b1;
                  end else begin
                    depth_d = depth_q - mtnc_pkg::DEPTH_W'(1);
                    if (top_q != hit_code) begin
                      err_d = 1'b1;
                    end
                  end
                end
              end
              mode_d = MODE_BETWEEN;
              cand_d = '0;
              pos_d  = '0;
            end else begin
              cand_d = keep;
              pos_d  = pos_inc;
            end
          end
          MODE_WORD: begin
            if (is_sep || (ch == mtnc_pkg::CHAR_LT)) begin
              if (word_reported) begin
                res0.token_kind  = mtnc_pkg::KIND_WORD;
                res0.word_length = pos_q;
                res0.last_result = 1'b1;
                fifo_push.wr0    = 1'b1;
              end
              lw_match_d = 1'b0;
              if (ch == mtnc_pkg::CHAR_LT) begin
                // The '<' that ends a word opens a tag
                mode_d = MODE_TAG;
                cand_d = '1;
                pos_d  = 8'd1;
              end else begin
                mode_d = MODE_BETWEEN;
                pos_d  = '0;
              end
            end else begin
              lw_match_d = lw_match_q
                        && (pos_q < 8'(mtnc_pkg::LINE_WORD_LEN))
                        && (mtnc_pkg::line_char(pos_q[4:0]) == ch);
              pos_d      = pos_inc;
            end
          end
          default: begin
            if (ch == mtnc_pkg::CHAR_LT) begin
              mode_d = MODE_TAG;
              cand_d = '1;
              pos_d  = 8'd1;
            end else if (!is_sep) begin
              mode_d     = MODE_WORD;
              pos_d      = 8'd1;
              lw_match_d = (ch == mtnc_pkg::line_char(5'd0));
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_BETWEEN;
      cand_q     <= '0;
      pos_q      <= '0;
      lw_match_q <= 1'b0;
      depth_q    <= '0;
      err_q      <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      cand_q     <= cand_d;
      pos_q      <= pos_d;
      lw_match_q <= lw_match_d;
      depth_q    <= depth_d;
      err_q      <= err_d;
    end
  end

  // Stack memory: write on push at the current depth, read the top entry
  assign top_addr = depth_q[mtnc_pkg::ADDR_W-1:0] - mtnc_pkg::ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_mem[depth_q[mtnc_pkg::ADDR_W-1:0]] <= push_code;
    end
    if (depth_q != '0) begin
      top_q <= stack_mem[top_addr];
    end
  end

  mtnc_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data0_i (res0),
    .data1_i (res1),
    .pop_i   (m_axis_tready),
    .head_o  (head),
    .valid_o (head_valid),
    .count_o (fifo_count)
  );

  assign m_axis_tvalid = head_valid;
  assign m_axis_tuser  = head.token_kind;
  assign m_axis_tdata  = {4'd0, head.well_formed, head.word_length, head.tag_code};
  assign m_axis_tlast  = head.last_result;

  // Checks
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= mtnc_pkg::DEPTH_W'(mtnc_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_end_restores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast) |=> (depth_q == '0) && !err_q && (mode_q == MODE_BETWEEN))
    else $error("end marker did not restore reset state");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(in_fire && s_axis_tlast)) |=> err_q)
    else $error("error flag cleared without end marker");

  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == mtnc_pkg::KIND_VERDICT)) |-> m_axis_tlast)
    else $error("verdict not marked as last result");

endmodule

`default_nettype wire
